// File: rtl/cjwm_pkg.sv
// cjwm_pkg: shared types and constants of the clock jump window monitor
// used by every module of the block, depends on nothing
`timescale 1ns / 1ps

package cjwm_pkg;

    localparam int TOP_K_DEF = 10;

    localparam int TS_W   = 63;
    localparam int BASE_W = 32;
    localparam int WLEN_W = 40;
    localparam int LIM_W  = 32;
    localparam int RANK_W = 4;
    localparam int FUNC_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [FUNC_W-1:0] FUNC_SAMPLE      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ_SINGLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ_WINDOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT = 2'd2;

    localparam logic [BASE_W-1:0] BASELINE_RST = '0;
    localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 40'd1000000;
    localparam logic [LIM_W-1:0]  JUMP_LIMIT_RST = '1;

    localparam logic [TS_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TS_W-1:0]   timestamp;
        logic [RANK_W-1:0] rank;
    } t_in;

    typedef struct packed {
        logic            jump_seen;
        logic [TS_W-1:0] jump_excess;
        logic            window_closed;
        logic [TS_W-1:0] closed_sum;
        logic            limit_reached;
        logic [TS_W-1:0] read_value;
    } t_out;

    typedef struct packed {
        logic            valid;
        logic [TS_W-1:0] value;
    } t_offer;

endpackage

// File: rtl/clock_jump_window_monitor.sv
// clock_jump_window_monitor: top level, sample tracking, window sum and two top-k rows
// depends on cjwm_pkg, cjwm_topk, cjwm_cell
`timescale 1ns / 1ps

// One transaction is taken every cycle while the output side is not stalled, and
// its result passes through the first-stage and output registers. The first stage
// forms the gap excess against a precomputed previous-time-plus-baseline and the
// window-close test against a precomputed window end; the second stage adds the
// excess into the saturating window sum and offers values to both top-k rows,
// whose cells each compare once against the offer and shift, and
// picks the read rank. Reads see every earlier sample. Register writes are to be
// made only while no transaction is in flight; the config port is always ready.
module clock_jump_window_monitor #(
    parameter int TOP_K = cjwm_pkg::TOP_K_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  cjwm_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cjwm_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cjwm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cjwm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int TW = cjwm_pkg::TS_W;

    // configuration
    logic [cjwm_pkg::BASE_W-1:0] r_baseline;
    logic [cjwm_pkg::WLEN_W-1:0] r_window_len;
    logic [cjwm_pkg::LIM_W-1:0]  r_jump_limit;

    // sample tracking state
    logic                       r_started,      n_started;
    logic [TW-1:0]              r_prev,         n_prev;
    logic [TW:0]                r_thresh,       n_thresh;
    logic [TW-1:0]              r_window_start, n_window_start;
    logic [TW:0]                r_window_end,   n_window_end;
    logic [cjwm_pkg::LIM_W-1:0] r_count,        n_count;

    // second stage
    logic                         r_s1_valid;
    logic [cjwm_pkg::FUNC_W-1:0]  r_s1_func;
    logic [cjwm_pkg::RANK_W-1:0]  r_s1_rank;
    logic                         r_s1_jump,   n_s1_jump;
    logic                         r_s1_close,  n_s1_close;
    logic [TW-1:0]                r_s1_excess, n_s1_excess;
    logic [TW-1:0]                r_wsum;

    logic           r_out_valid;
    cjwm_pkg::t_out r_out_data;
    cjwm_pkg::t_out w_result;

    logic                       w_in_fire;
    logic                       w_adv;
    logic [cjwm_pkg::LIM_W-1:0] w_limit;
    logic                       w_at_limit;
    logic                       w_is_jump;
    logic [TW:0]                w_sum_raw;
    logic [TW-1:0]              w_sum_sat;
    logic [TW-1:0]              w_single_rd;
    logic [TW-1:0]              w_window_rd;
    cjwm_pkg::t_offer           w_single_offer;
    cjwm_pkg::t_offer           w_window_offer;

    assign w_adv       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_adv;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_limit    = (r_jump_limit == '0) ? cjwm_pkg::LIM_W'(1) : r_jump_limit;
    assign w_at_limit = r_started && (r_count >= w_limit);
    assign w_is_jump  = {1'b0, i_in_data.timestamp} > r_thresh;

    // first stage: gap test and window bookkeeping
    always_comb begin
        n_started      = r_started;
        n_prev         = r_prev;
        n_thresh       = r_thresh;
        n_window_start = r_window_start;
        n_window_end   = r_window_end;
        n_count        = r_count;
        n_s1_jump      = 1'b0;
        n_s1_close     = 1'b0;
        n_s1_excess    = TW'({1'b0, i_in_data.timestamp} - r_thresh);
        if (w_in_fire && i_in_data.func == cjwm_pkg::FUNC_SAMPLE) begin
            if (!r_started) begin
                n_started      = 1'b1;
                n_prev         = i_in_data.timestamp;
                n_thresh       = {1'b0, i_in_data.timestamp} + (TW+1)'(r_baseline);
                n_window_start = i_in_data.timestamp;
                n_window_end   = {1'b0, i_in_data.timestamp} + (TW+1)'(r_window_len);
                n_count        = cjwm_pkg::LIM_W'(1);
            end else if (!w_at_limit) begin
                n_prev   = i_in_data.timestamp;
                n_thresh = {1'b0, i_in_data.timestamp} + (TW+1)'(r_baseline);
                if (w_is_jump) begin
                    n_s1_jump = 1'b1;
                    n_count   = r_count + 1'b1;
                    if ({1'b0, r_prev} >= r_window_end) begin
                        n_s1_close     = 1'b1;
                        n_window_start = r_prev;
                        n_window_end   = {1'b0, r_prev} + (TW+1)'(r_window_len);
                    end
                end
            end
        end
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cjwm_pkg::CFG_BASELINE: begin
                    n_thresh = {1'b0, r_prev}
                               + (TW+1)'(i_cfg_data[cjwm_pkg::BASE_W-1:0]);
                end
                cjwm_pkg::CFG_WINDOW_LEN: begin
                    n_window_end = {1'b0, r_window_start}
                                   + (TW+1)'(i_cfg_data[cjwm_pkg::WLEN_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline     <= cjwm_pkg::BASELINE_RST;
            r_window_len   <= cjwm_pkg::WINDOW_LEN_RST;
            r_jump_limit   <= cjwm_pkg::JUMP_LIMIT_RST;
            r_started      <= 1'b0;
            r_prev         <= '0;
            r_thresh       <= '0;
            r_window_start <= '0;
            r_window_end   <= (TW+1)'(cjwm_pkg::WINDOW_LEN_RST);
            r_count        <= '0;
        end else begin
            r_started      <= n_started;
            r_prev         <= n_prev;
            r_thresh       <= n_thresh;
            r_window_start <= n_window_start;
            r_window_end   <= n_window_end;
            r_count        <= n_count;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    cjwm_pkg::CFG_BASELINE: begin
                        r_baseline <= i_cfg_data[cjwm_pkg::BASE_W-1:0];
                    end
                    cjwm_pkg::CFG_WINDOW_LEN: begin
                        r_window_len <= i_cfg_data[cjwm_pkg::WLEN_W-1:0];
                    end
                    cjwm_pkg::CFG_JUMP_LIMIT: begin
                        r_jump_limit <= i_cfg_data[cjwm_pkg::LIM_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= w_in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_func   <= i_in_data.func;
            r_s1_rank   <= i_in_data.rank;
            r_s1_jump   <= n_s1_jump;
            r_s1_close  <= n_s1_close;
            r_s1_excess <= n_s1_excess;
        end
    end

    // second stage: window sum, store offers and rank read
    assign w_sum_raw = {1'b0, r_wsum} + {1'b0, r_s1_excess};
    assign w_sum_sat = w_sum_raw[TW] ? cjwm_pkg::SUM_MAX : w_sum_raw[TW-1:0];

    assign w_single_offer.valid = w_adv && r_s1_jump;
    assign w_single_offer.value = r_s1_excess;
    assign w_window_offer.valid = w_adv && r_s1_jump && r_s1_close;
    assign w_window_offer.value = w_sum_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum <= '0;
        end else if (w_adv && r_s1_jump) begin
            r_wsum <= r_s1_close ? '0 : w_sum_sat;
        end
    end

    cjwm_topk #(.TOP_K(TOP_K)) u_single_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_offer      (w_single_offer),
        .i_rank       (r_s1_rank),
        .o_read_value (w_single_rd)
    );

    cjwm_topk #(.TOP_K(TOP_K)) u_window_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_offer      (w_window_offer),
        .i_rank       (r_s1_rank),
        .o_read_value (w_window_rd)
    );

    always_comb begin
        w_result               = '0;
        w_result.jump_seen     = r_s1_jump;
        w_result.jump_excess   = r_s1_jump ? r_s1_excess : '0;
        w_result.window_closed = r_s1_jump && r_s1_close;
        w_result.closed_sum    = (r_s1_jump && r_s1_close) ? w_sum_sat : '0;
        w_result.limit_reached = w_at_limit;
        case (r_s1_func)
            cjwm_pkg::FUNC_READ_SINGLE: w_result.read_value = w_single_rd;
            cjwm_pkg::FUNC_READ_WINDOW: w_result.read_value = w_window_rd;
            default:                    w_result.read_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_result;
        end
    end

    a_window_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window_end == ({1'b0, r_window_start} + (TW+1)'(r_window_len)))
        else $error("window end out of step with window start and length");

    a_thresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_thresh == ({1'b0, r_prev} + (TW+1)'(r_baseline)))
        else $error("jump threshold out of step with previous time");

    a_jump_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_jump) |-> (r_started && r_count > cjwm_pkg::LIM_W'(1)))
        else $error("jump recorded without a start record");

    a_close_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.window_closed || o_out_data.jump_seen))
        else $error("window closed without a jump");

endmodule

// File: rtl/cjwm_cell.sv
// cjwm_cell: one entry of a sorted top-k row, compares the offered value
// and takes its upper neighbor's value or the offer; depends on cjwm_pkg
`timescale 1ns / 1ps

module cjwm_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cjwm_pkg::t_offer              i_offer,
    input  logic                          i_up_lt,
    input  logic [cjwm_pkg::TS_W-1:0]     i_up_val,
    output logic                          o_lt,
    output logic [cjwm_pkg::TS_W-1:0]     o_val
);

    logic [cjwm_pkg::TS_W-1:0] r_val;
    logic [cjwm_pkg::TS_W-1:0] n_val;

    assign o_lt  = i_offer.valid && (r_val < i_offer.value);
    assign o_val = r_val;

    always_comb begin
        if (i_up_lt) begin
            n_val = i_up_val;
        end else if (o_lt) begin
            n_val = i_offer.value;
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= n_val;
        end
    end

endmodule

// File: rtl/cjwm_topk.sv
// cjwm_topk: row of cjwm_cell entries kept ascending, with rank read select
// depends on cjwm_pkg and cjwm_cell
`timescale 1ns / 1ps

module cjwm_topk #(
    parameter int TOP_K = cjwm_pkg::TOP_K_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cjwm_pkg::t_offer              i_offer,
    input  logic [cjwm_pkg::RANK_W-1:0]   i_rank,
    output logic [cjwm_pkg::TS_W-1:0]     o_read_value
);

    logic                      w_lt  [TOP_K+1];
    logic [cjwm_pkg::TS_W-1:0] w_val [TOP_K+1];

    assign w_lt[TOP_K]  = 1'b0;
    assign w_val[TOP_K] = '0;

    for (genvar g = 0; g < TOP_K; g++) begin : g_cell
        cjwm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_offer  (i_offer),
            .i_up_lt  (w_lt[g+1]),
            .i_up_val (w_val[g+1]),
            .o_lt     (w_lt[g]),
            .o_val    (w_val[g])
        );
    end

    // rank 0 is the top cell, ranks past the row read zero
    always_comb begin
        o_read_value = '0;
        for (int i = 0; i < TOP_K; i++) begin
            if ({1'b0, i_rank} == (cjwm_pkg::RANK_W+1)'(TOP_K - 1 - i)) begin
                o_read_value = w_val[i];
            end
        end
    end

endmodule
